>>> src/llbh_pkg.sv
// llbh_pkg: shared types, constants and codes for the least loaded bucket heap
// no dependencies; imported by every module under src
package llbh_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int LOAD_BITS   = 16;
  localparam int POS_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ID_W        = 4;
  localparam int NEWLOAD_W   = 16;
  localparam int STATUS_W    = 2;

  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [LOAD_BITS-1:0] load_t;

  typedef struct packed {
    pos_t  bucket;
    load_t load;
  } slot_t;

  typedef enum logic {
    FN_ASSIGN  = 1'b0,
    FN_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_DEC,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    load_t res;
    logic  lt;
    logic  is_max;
    logic  is_zero;
  } alu_out_t;

  // one read and one write per memory per cycle
  typedef struct packed {
    pos_t  h_raddr;
    logic  h_we;
    pos_t  h_waddr;
    slot_t h_wdata;
    pos_t  p_raddr;
    logic  p_we;
    pos_t  p_waddr;
    pos_t  p_wdata;
  } st_req_t;

  typedef struct packed {
    logic    vld;
    pos_t    bucket;
    load_t   load;
    status_t status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_POS,
    S_ENT,
    S_UP_CHK,
    S_UP_CMP,
    S_DONE
  } state_t;

endpackage

>>> src/llbh_store.sv
// llbh_store: heap slot memory and bucket-to-position memory, registered reads
// depends on llbh_pkg; unwritten entries read as their reset contents
module llbh_store (
  input  logic             clk,
  input  logic             rst_n,
  input  llbh_pkg::st_req_t req,
  output llbh_pkg::slot_t  h_rdata,
  output llbh_pkg::pos_t   p_rdata
);
  import llbh_pkg::*;

  slot_t heap_mem [NUM_BUCKETS];
  pos_t  pos_mem  [NUM_BUCKETS];

  logic [NUM_BUCKETS-1:0] h_vld_r;
  logic [NUM_BUCKETS-1:0] p_vld_r;

  slot_t h_q_r;
  pos_t  p_q_r;
  pos_t  h_addr_r;
  pos_t  p_addr_r;
  logic  h_qv_r;
  logic  p_qv_r;

  always_ff @(posedge clk) begin
    if (req.h_we) begin
      heap_mem[req.h_waddr] <= req.h_wdata;
    end
    if (req.p_we) begin
      pos_mem[req.p_waddr] <= req.p_wdata;
    end
    h_q_r    <= heap_mem[req.h_raddr];
    p_q_r    <= pos_mem[req.p_raddr];
    h_addr_r <= req.h_raddr;
    p_addr_r <= req.p_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= '0;
      p_vld_r <= '0;
      h_qv_r  <= 1'b0;
      p_qv_r  <= 1'b0;
    end else begin
      if (req.h_we) begin
        h_vld_r[req.h_waddr] <= 1'b1;
      end
      if (req.p_we) begin
        p_vld_r[req.p_waddr] <= 1'b1;
      end
      h_qv_r <= h_vld_r[req.h_raddr];
      p_qv_r <= p_vld_r[req.p_raddr];
    end
  end

  // entry i starts as bucket i with zero load, bucket i at position i
  always_comb begin
    if (h_qv_r) begin
      h_rdata = h_q_r;
    end else begin
      h_rdata.bucket = h_addr_r;
      h_rdata.load   = '0;
    end
    p_rdata = p_qv_r ? p_q_r : p_addr_r;
  end

endmodule

>>> src/llbh_alu.sv
// llbh_alu: shared load unit, increment, decrement and less-than compare
// depends on llbh_pkg
module llbh_alu (
  input  llbh_pkg::alu_op_t  op,
  input  llbh_pkg::load_t    a,
  input  llbh_pkg::load_t    b,
  output llbh_pkg::alu_out_t res
);
  import llbh_pkg::*;

  always_comb begin
    res.is_max  = (a == LOAD_MAX);
    res.is_zero = (a == '0);
    res.lt      = (a < b);
    unique case (op)
      ALU_INC: res.res = a + load_t'(1);
      ALU_DEC: res.res = a - load_t'(1);
      default: res.res = a;
    endcase
  end

endmodule

>>> src/llbh_ctrl.sv
// llbh_ctrl: sequencer for root assign with sift down and release with sift up
// depends on llbh_pkg and llbh_alu; drives the memory requests of llbh_store
module llbh_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  func,
  input  logic [llbh_pkg::ID_W-1:0] bucket_id,
  input  logic                  res_take,
  input  llbh_pkg::slot_t       h_rdata,
  input  llbh_pkg::pos_t        p_rdata,
  output llbh_pkg::st_req_t     req,
  output logic                  busy,
  output llbh_pkg::result_t     result
);
  import llbh_pkg::*;

  localparam int CW = POS_W + 1;
  localparam logic [CW-1:0] NB_C = CW'(NUM_BUCKETS);

  state_t state_r, state_nxt;

  slot_t mov_r, mov_nxt;
  pos_t  pos_r, pos_nxt;
  slot_t child_r, child_nxt;
  pos_t  cidx_r, cidx_nxt;
  logic  [ID_W-1:0] id_r, id_nxt;
  result_t res_r, res_nxt;

  alu_op_t  alu_op;
  load_t    alu_a;
  load_t    alu_b;
  alu_out_t alu_q;

  logic [CW-1:0] left_w;
  logic          has_left;
  logic          has_right;
  pos_t          left_idx;
  pos_t          right_idx;
  pos_t          par_idx;
  logic          id_ok;
  logic          swap_dn;
  logic          swap_up;

  llbh_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_q)
  );

  assign left_w    = {pos_r, 1'b1};
  assign has_left  = (left_w < NB_C);
  assign has_right = (left_w < NB_C - CW'(1));
  assign left_idx  = left_w[POS_W-1:0];
  assign right_idx = left_idx + pos_t'(1);
  assign par_idx   = (pos_r - pos_t'(1)) >> 1;
  assign id_ok     = (32'(id_r) < NUM_BUCKETS);
  assign swap_dn   = alu_q.lt;
  assign swap_up   = alu_q.lt;

  // shared unit operand selection
  always_comb begin
    alu_op = ALU_LT;
    alu_a  = mov_r.load;
    alu_b  = h_rdata.load;
    unique case (state_r)
      S_ROOT: begin
        alu_op = ALU_INC;
        alu_a  = h_rdata.load;
      end
      S_ENT: begin
        alu_op = ALU_DEC;
        alu_a  = h_rdata.load;
      end
      S_DN_R: begin
        alu_a = child_r.load;
        alu_b = h_rdata.load;
      end
      S_DN_CMP: begin
        alu_a = child_r.load;
        alu_b = mov_r.load;
      end
      S_UP_CMP: begin
        alu_a = mov_r.load;
        alu_b = h_rdata.load;
      end
      default: begin
        alu_op = ALU_LT;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (func == FN_RELEASE) ? S_POS : S_ROOT;
        end
      end
      S_ROOT:   state_nxt = alu_q.is_max ? S_DONE : S_DN_CHK;
      S_DN_CHK: state_nxt = has_left ? S_DN_L : S_DONE;
      S_DN_L:   state_nxt = has_right ? S_DN_R : S_DN_CMP;
      S_DN_R:   state_nxt = S_DN_CMP;
      S_DN_CMP: state_nxt = swap_dn ? S_DN_CHK : S_DONE;
      S_POS:    state_nxt = id_ok ? S_ENT : S_DONE;
      S_ENT:    state_nxt = alu_q.is_zero ? S_DONE : S_UP_CHK;
      S_UP_CHK: state_nxt = (pos_r == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP: state_nxt = swap_up ? S_UP_CHK : S_DONE;
      S_DONE:   state_nxt = res_take ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    req         = '0;
    req.h_wdata = mov_r;
    req.h_waddr = pos_r;
    req.p_waddr = mov_r.bucket;
    req.p_wdata = pos_r;
    unique case (state_r)
      S_IDLE: begin
        req.h_raddr = '0;
        req.p_raddr = pos_t'(bucket_id);
      end
      S_POS: begin
        req.h_raddr = p_rdata;
      end
      S_DN_CHK: begin
        req.h_raddr = left_idx;
        if (!has_left) begin
          req.h_we = 1'b1;
          req.p_we = 1'b1;
        end
      end
      S_DN_L: begin
        req.h_raddr = right_idx;
      end
      S_DN_CMP: begin
        req.h_we = 1'b1;
        req.p_we = 1'b1;
        if (swap_dn) begin
          req.h_wdata = child_r;
          req.p_waddr = child_r.bucket;
        end
      end
      S_UP_CHK: begin
        req.h_raddr = par_idx;
        if (pos_r == '0) begin
          req.h_we = 1'b1;
          req.p_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        req.h_we = 1'b1;
        req.p_we = 1'b1;
        if (swap_up) begin
          req.h_wdata = h_rdata;
          req.p_waddr = h_rdata.bucket;
        end
      end
      default: begin
        req.h_we = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    mov_nxt   = mov_r;
    pos_nxt   = pos_r;
    child_nxt = child_r;
    cidx_nxt  = cidx_r;
    id_nxt    = id_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        id_nxt  = bucket_id;
        res_nxt = '0;
      end
      S_ROOT: begin
        res_nxt.bucket = h_rdata.bucket;
        if (alu_q.is_max) begin
          res_nxt.load   = h_rdata.load;
          res_nxt.status = ST_SAT;
        end else begin
          res_nxt.load   = alu_q.res;
          res_nxt.status = ST_OK;
        end
        mov_nxt.bucket = h_rdata.bucket;
        mov_nxt.load   = alu_q.res;
        pos_nxt        = '0;
      end
      S_DN_L: begin
        child_nxt = h_rdata;
        cidx_nxt  = left_idx;
      end
      S_DN_R: begin
        // right child wins ties
        if (!alu_q.lt) begin
          child_nxt = h_rdata;
          cidx_nxt  = right_idx;
        end
      end
      S_DN_CMP: begin
        if (swap_dn) begin
          pos_nxt = cidx_r;
        end
      end
      S_POS: begin
        pos_nxt        = p_rdata;
        res_nxt.bucket = pos_t'(id_r);
        res_nxt.load   = '0;
        res_nxt.status = ST_EMPTY;
      end
      S_ENT: begin
        if (!alu_q.is_zero) begin
          res_nxt.load   = alu_q.res;
          res_nxt.status = ST_OK;
        end
        mov_nxt.bucket = pos_t'(id_r);
        mov_nxt.load   = alu_q.res;
      end
      S_UP_CMP: begin
        if (swap_up) begin
          pos_nxt = par_idx;
        end
      end
      default: begin
        mov_nxt = mov_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mov_r   <= mov_nxt;
    pos_r   <= pos_nxt;
    child_r <= child_nxt;
    cidx_r  <= cidx_nxt;
    id_r    <= id_nxt;
    res_r   <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    result     = res_r;
    result.vld = (state_r == S_DONE);
  end

endmodule

>>> src/least_loaded_bucket_heap.sv
// least_loaded_bucket_heap: top level, indexed min-heap of bucket loads
// depends on llbh_pkg, llbh_store and llbh_ctrl; holds the result register
//
//   channel  ports                                          direction
//   in       in_valid in_stall in_func in_bucket_id         to block
//   out      out_valid out_stall out_chosen_bucket
//            out_new_load out_status                         from block
//
// an assign reads and increments the root, then per level it sinks reads the left
// and, if present, the right child in turn, as the heap port has a single read; a
// release reads the bucket's position, then decrements its load and per level it
// rises reads the parent; a saturated assign or an empty release moves no entry
// reset is synchronous and active low; memories need no clearing pass
// a finished result frees the sequencer into the output register, else it waits
// in its last state with in_stall high while that register is full and stalled
module least_loaded_bucket_heap (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [llbh_pkg::ID_W-1:0]          in_bucket_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [llbh_pkg::ID_W-1:0]          out_chosen_bucket,
  output logic [llbh_pkg::NEWLOAD_W-1:0]     out_new_load,
  output logic [llbh_pkg::STATUS_W-1:0]      out_status
);
  import llbh_pkg::*;

  st_req_t req;
  slot_t   h_rdata;
  pos_t    p_rdata;
  logic    busy;
  result_t result;
  logic    start;
  logic    res_take;

  logic                 out_valid_r;
  logic [ID_W-1:0]      out_bucket_r;
  logic [NEWLOAD_W-1:0] out_load_r;
  logic [STATUS_W-1:0]  out_status_r;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign res_take = result.vld && (!out_valid_r || !out_stall);

  llbh_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .h_rdata (h_rdata),
    .p_rdata (p_rdata)
  );

  llbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_func),
    .bucket_id (in_bucket_id),
    .res_take  (res_take),
    .h_rdata   (h_rdata),
    .p_rdata   (p_rdata),
    .req       (req),
    .busy      (busy),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_bucket_r <= ID_W'(result.bucket);
      out_load_r   <= NEWLOAD_W'(result.load);
      out_status_r <= result.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_bucket = out_bucket_r;
  assign out_new_load      = out_load_r;
  assign out_status        = out_status_r;

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for least_loaded_bucket_heap, heap predictor and result queue
// depends on llbh_pkg and the block under src; needs no files or arguments at run time
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llbh_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int BLOCK_ITEMS  = 50;
  localparam int RANDOM_ITEMS = 850;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [ID_W-1:0]      bucket;
    logic [NEWLOAD_W-1:0] load;
    status_t              status;
  } grant_t;

  class bucket_heap_tracker;
    pos_t   slot_bucket[NUM_BUCKETS];
    load_t  slot_load[NUM_BUCKETS];
    pos_t   bucket_slot[NUM_BUCKETS];
    grant_t pending_grants[$];
    int unsigned n_assign, n_release, n_empty, n_checked, errors;
    load_t  peak_load;

    function new();
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        slot_bucket[i] = pos_t'(i);
        slot_load[i]   = '0;
        bucket_slot[i] = pos_t'(i);
      end
      peak_load = '0;
    endfunction

    function void exchange(int a, int b);
      pos_t  hold_bucket;
      load_t hold_load;
      hold_bucket = slot_bucket[a];
      hold_load   = slot_load[a];
      slot_bucket[a] = slot_bucket[b];
      slot_load[a]   = slot_load[b];
      slot_bucket[b] = hold_bucket;
      slot_load[b]   = hold_load;
      bucket_slot[slot_bucket[a]] = pos_t'(a);
      bucket_slot[slot_bucket[b]] = pos_t'(b);
    endfunction

    // ties go to the right child
    function void sink(int p);
      int l, r, pick;
      while (2 * p + 1 < NUM_BUCKETS) begin
        l = 2 * p + 1;
        r = l + 1;
        pick = l;
        if (r < NUM_BUCKETS && !(slot_load[l] < slot_load[r])) pick = r;
        if (slot_load[p] > slot_load[pick]) begin
          exchange(p, pick);
          p = pick;
        end else begin
          break;
        end
      end
    endfunction

    function void rise(int p);
      int up;
      while (p > 0) begin
        up = (p - 1) / 2;
        if (slot_load[p] < slot_load[up]) begin
          exchange(p, up);
          p = up;
        end else begin
          break;
        end
      end
    endfunction

    function grant_t predict_grant(func_t f, logic [ID_W-1:0] id);
      grant_t g;
      int p;
      g.status = ST_OK;
      if (f == FN_ASSIGN) begin
        n_assign++;
        g.bucket = slot_bucket[0];
        if (slot_load[0] == LOAD_MAX) begin
          g.load   = slot_load[0];
          g.status = ST_SAT;
        end else begin
          slot_load[0] = slot_load[0] + 1'b1;
          g.load = slot_load[0];
          sink(0);
        end
      end else begin
        n_release++;
        g.bucket = id;
        g.load   = '0;
        if (int'(id) >= NUM_BUCKETS) begin
          g.status = ST_EMPTY;
        end else begin
          p = bucket_slot[id];
          if (slot_load[p] == '0) begin
            g.status = ST_EMPTY;
          end else begin
            slot_load[p] = slot_load[p] - 1'b1;
            g.load = slot_load[p];
            rise(p);
          end
        end
        if (g.status == ST_EMPTY) n_empty++;
      end
      if (g.load > peak_load) peak_load = g.load;
      return g;
    endfunction

    function void note_request(func_t f, logic [ID_W-1:0] id);
      pending_grants.insert(pending_grants.size(), predict_grant(f, id));
    endfunction

    // a random bucket that still carries load, so that most releases do real work
    function pos_t loaded_bucket();
      pos_t busy[$];
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        if (slot_load[bucket_slot[b]] != '0) busy.insert(busy.size(), pos_t'(b));
      end
      if (busy.size() == 0) return pos_t'($urandom_range(0, NUM_BUCKETS - 1));
      return busy[$urandom_range(0, busy.size() - 1)];
    endfunction

    task log_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_grant(logic [ID_W-1:0] bucket, logic [NEWLOAD_W-1:0] load,
                     logic [STATUS_W-1:0] status);
      grant_t e;
      n_checked++;
      if (pending_grants.size() == 0) begin
        log_mismatch($sformatf("result bucket %0d load %0d status %0d with nothing outstanding",
                               bucket, load, status));
      end else begin
        e = pending_grants.pop_front();
        if (bucket !== e.bucket || load !== e.load || status !== e.status)
          log_mismatch($sformatf("got bucket %0d load %0d status %0d, want %0d %0d %0d",
                                 bucket, load, status, e.bucket, e.load, e.status));
      end
    endtask
  endclass

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_func      = 1'b0;
  logic [ID_W-1:0]        in_bucket_id = '0;
  logic                   out_stall    = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [ID_W-1:0]        out_chosen_bucket;
  logic [NEWLOAD_W-1:0]   out_new_load;
  logic [STATUS_W-1:0]    out_status;

  bucket_heap_tracker tracker = new();

  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned mode_left   = 0;
  bit          rx_calm     = 1'b0;

  least_loaded_bucket_heap i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_bucket_id      (in_bucket_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chosen_bucket (out_chosen_bucket),
    .out_new_load      (out_new_load),
    .out_status        (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // transfers on both channels are picked up here, input first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_request(func_t'(in_func), in_bucket_id);
      if (out_valid && !out_stall)
        tracker.check_grant(out_chosen_bucket, out_new_load, out_status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side back-pressure, with calm stretches of no stall at all
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_calm   <= ($urandom_range(0, 3) == 0);
      mode_left <= $urandom_range(100, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(func_t f, logic [ID_W-1:0] id, bit no_gaps);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_func      <= f;
    in_bucket_id <= id;
    do @(posedge clk); while (in_stall);
    if (!no_gaps && $urandom_range(0, 1) == 1) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_grants.size() != 0);
  endtask

  initial begin
    int unsigned assign_pct;
    bit          no_gaps;
    func_t       f;
    pos_t        id;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // releases on empty buckets at both ends of the id range
    send_item(FN_RELEASE, ID_W'(0), 1'b0);
    send_item(FN_RELEASE, ID_W'(NUM_BUCKETS - 1), 1'b0);
    // one load on every bucket through equal-load ties, then one bucket up to two
    repeat (NUM_BUCKETS + 1) send_item(FN_ASSIGN, ID_W'($urandom_range(0, 15)), 1'b0);
    send_item(FN_RELEASE, ID_W'(NUM_BUCKETS - 1), 1'b0);
    send_item(FN_RELEASE, ID_W'(0), 1'b0);
    send_item(FN_RELEASE, ID_W'(0), 1'b0);
    send_item(FN_ASSIGN, ID_W'(15), 1'b0);
    send_item(FN_ASSIGN, ID_W'(0), 1'b0);
    wait_drained();

    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      case (blk % 4)
        0:       assign_pct = 85;
        1:       assign_pct = 55;
        2:       assign_pct = 25;
        default: assign_pct = $urandom_range(40, 70);
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        if ($urandom_range(0, 99) < assign_pct) begin
          f  = FN_ASSIGN;
          id = pos_t'($urandom_range(0, 15));
        end else begin
          f  = FN_RELEASE;
          id = ($urandom_range(0, 99) < 85) ? tracker.loaded_bucket()
                                            : pos_t'($urandom_range(0, 15));
        end
        send_item(f, id, no_gaps);
      end
      if (blk == 8) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d assigns and %0d releases, %0d of them on empty buckets; peak load %0d",
             tracker.n_assign, tracker.n_release, tracker.n_empty, tracker.peak_load);
    $display("%0d results checked, %0d mismatches", tracker.n_checked, tracker.errors);
    if (tracker.errors == 0 && tracker.pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
